// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; expect clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== hw/rtl/iasd_pkg.sv =====
package iasd_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 24;
  localparam int unsigned OUT_LEN_W       = 24;
  localparam int unsigned CNT_EXT_W       = 32;

  localparam logic [7:0] TAG_GROUP_LO_END = 8'h02;
  localparam logic [7:0] TAG_END          = 8'h03;
  localparam logic [7:0] TAG_GROUP_HI_BEG = 8'h04;
  localparam logic [7:0] TAG_GROUP_HI_END = 8'h0F;

  typedef enum logic [3:0] {
    PH_TOP       = 4'd0,
    PH_GROUP     = 4'd1,
    PH_NAME_HI   = 4'd2,
    PH_NAME_LO   = 4'd3,
    PH_NAME_SKIP = 4'd4,
    PH_VAL_HI    = 4'd5,
    PH_VAL_LO    = 4'd6,
    PH_VAL_SKIP  = 4'd7,
    PH_DRAIN     = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADTAG = 2'd1,
    ST_TRUNC  = 2'd2,
    ST_OVF    = 2'd3
  } status_t;

  typedef struct packed {
    status_t               status;
    logic [OUT_LEN_W-1:0]  section_length;
  } result_t;

  function automatic logic is_group_tag(input logic [7:0] t);
    return (t <= TAG_GROUP_LO_END) || ((t >= TAG_GROUP_HI_BEG) && (t <= TAG_GROUP_HI_END));
  endfunction

endpackage

// ===== hw/rtl/iasd_parser.sv =====
// Attribute section walker: one byte per accepted request, result is combinational.
module iasd_parser #(
  parameter int unsigned LENGTH_BITS = iasd_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_acc,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               res_valid,
  output iasd_pkg::result_t  res,
  output iasd_pkg::phase_t   phase
);

  iasd_pkg::phase_t        phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0]  count_r, count_nxt;
  logic [15:0]             skip_r, skip_nxt;
  logic [7:0]              len_hi_r, len_hi_nxt;
  logic [LENGTH_BITS-1:0]  count_inc;
  logic [iasd_pkg::CNT_EXT_W-1:0] count_ext;
  logic [15:0]             len_full;

  assign count_inc = count_r + LENGTH_BITS'(1);
  assign count_ext = iasd_pkg::CNT_EXT_W'(count_inc);
  assign len_full  = {len_hi_r, data_byte};
  assign phase     = phase_r;

  always_comb begin
    phase_nxt          = phase_r;
    count_nxt          = count_r;
    skip_nxt           = skip_r;
    len_hi_nxt         = len_hi_r;
    res_valid          = 1'b0;
    res.status         = iasd_pkg::ST_OK;
    res.section_length = '0;
    if (req_acc) begin
      if (phase_r == iasd_pkg::PH_DRAIN) begin
        // silent until the last byte
      end else if (count_r == {LENGTH_BITS{1'b1}}) begin
        res_valid  = 1'b1;
        res.status = iasd_pkg::ST_OVF;
        phase_nxt  = iasd_pkg::PH_DRAIN;
      end else begin
        count_nxt = count_inc;
        case (phase_r)
          iasd_pkg::PH_TOP, iasd_pkg::PH_GROUP: begin
            if (data_byte == iasd_pkg::TAG_END) begin
              res_valid          = 1'b1;
              res.section_length = count_ext[iasd_pkg::OUT_LEN_W-1:0];
              phase_nxt          = iasd_pkg::PH_DRAIN;
            end else if (iasd_pkg::is_group_tag(data_byte)) begin
              phase_nxt = iasd_pkg::PH_GROUP;
            end else if (phase_r == iasd_pkg::PH_TOP) begin
              res_valid  = 1'b1;
              res.status = iasd_pkg::ST_BADTAG;
              phase_nxt  = iasd_pkg::PH_DRAIN;
            end else begin
              phase_nxt = iasd_pkg::PH_NAME_HI;
            end
          end
          iasd_pkg::PH_NAME_HI: begin
            len_hi_nxt = data_byte;
            phase_nxt  = iasd_pkg::PH_NAME_LO;
          end
          iasd_pkg::PH_VAL_HI: begin
            len_hi_nxt = data_byte;
            phase_nxt  = iasd_pkg::PH_VAL_LO;
          end
          iasd_pkg::PH_NAME_LO: begin
            skip_nxt  = len_full;
            phase_nxt = (len_full != 16'd0) ? iasd_pkg::PH_NAME_SKIP : iasd_pkg::PH_VAL_HI;
          end
          iasd_pkg::PH_VAL_LO: begin
            skip_nxt  = len_full;
            phase_nxt = (len_full != 16'd0) ? iasd_pkg::PH_VAL_SKIP : iasd_pkg::PH_GROUP;
          end
          iasd_pkg::PH_NAME_SKIP: begin
            skip_nxt = skip_r - 16'd1;
            if (skip_r == 16'd1) begin
              phase_nxt = iasd_pkg::PH_VAL_HI;
            end
          end
          iasd_pkg::PH_VAL_SKIP: begin
            skip_nxt = skip_r - 16'd1;
            if (skip_r == 16'd1) begin
              phase_nxt = iasd_pkg::PH_GROUP;
            end
          end
          default: begin
          end
        endcase
        // stream ended mid-section
        if (last_byte && !res_valid) begin
          res_valid  = 1'b1;
          res.status = iasd_pkg::ST_TRUNC;
        end
      end
      if (last_byte) begin
        phase_nxt  = iasd_pkg::PH_TOP;
        count_nxt  = '0;
        skip_nxt   = '0;
        len_hi_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= iasd_pkg::PH_TOP;
      count_r  <= '0;
      skip_r   <= '0;
      len_hi_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      skip_r   <= skip_nxt;
      len_hi_r <= len_hi_nxt;
    end
  end

endmodule

// ===== hw/rtl/iasd_skid.sv =====
// Result register with one skid entry.
module iasd_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  iasd_pkg::result_t  push_data,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output iasd_pkg::result_t  out_data
);

  logic               main_valid_r;
  logic               skid_valid_r;
  iasd_pkg::result_t  main_r;
  iasd_pkg::result_t  skid_r;
  logic               take;

  assign take      = main_valid_r && out_ready;
  assign can_push  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || take) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (!main_valid_r || take) begin
        main_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

endmodule

// ===== hw/rtl/ipp_attribute_section_delimiter_unit.sv =====
// Each result is registered (main register or skid entry) before it drives out_tvalid.
// Throughput: one byte per cycle while in_tready is high; the parser state is registered.
// in_tready drops only while both the result register and its skid entry hold results.
// Reset: synchronous, active-low rst_n; parser returns to top level, results dropped.
module ipp_attribute_section_delimiter_unit #(
  parameter int unsigned LENGTH_BITS = iasd_pkg::LENGTH_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata   // [1:0] status, [25:2] section_length, [31:26] zero
);

  // A request is consumed whenever in_tvalid and in_tready meet.
  logic               req_acc;
  logic               res_valid;
  iasd_pkg::result_t  res;
  iasd_pkg::result_t  out_res;
  iasd_pkg::phase_t   phase;

  assign req_acc = in_tvalid && in_tready;

  // Walks tags, length fields and skipped name/value bytes.
  iasd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_acc   (req_acc),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .res_valid (res_valid),
    .res       (res),
    .phase     (phase)
  );

  // Output register plus skid: input keeps flowing while a result waits.
  iasd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .can_push  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {6'd0, out_res.section_length, out_res.status};

`include "assert_macros.svh"

  // Skid is only filled while the main register is occupied.
  `ASSERT_NOW(a_skid_implies_main, !in_tready, out_tvalid)
  // Error results never carry a length.
  `ASSERT_NOW(a_err_len_zero, out_tvalid && (out_tdata[1:0] != iasd_pkg::ST_OK), out_tdata[25:2] == 24'd0)
  // A last byte always rearms the parser.
  `ASSERT_NEXT(a_last_rearms, req_acc && in_tlast, phase == iasd_pkg::PH_TOP)

endmodule
